[src/simon_pkg.sv]
// Shared types, constants and round functions for the Simon 128/128 cipher.
// Used by the channel interfaces, the key store and the top level.
`timescale 1ns / 1ps
`default_nettype none

package simon_pkg;

   localparam int WORD_W       = 64;
   localparam int SIMON_ROUNDS = 68;
   localparam int KEY_DEPTH    = 68;
   localparam int KADDR_W      = $clog2(KEY_DEPTH);
   localparam int Z_LEN        = 62;
   localparam int ZIDX_W       = $clog2(Z_LEN);
   localparam int CSR_IDX_W    = 4;

   localparam logic [Z_LEN-1:0]  Z2_SEQ  = 62'h2BDC0D262847E5B3;
   localparam logic [WORD_W-1:0] CONST_C = 64'hFFFFFFFFFFFFFFFC;

   localparam logic [CSR_IDX_W-1:0] CSR_IDX_KEY_LOW  = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IDX_KEY_HIGH = 4'd1;

   localparam logic CMD_ENCRYPT = 1'b0;
   localparam logic CMD_DECRYPT = 1'b1;

   typedef logic [WORD_W-1:0] word_type;

   // Request to the key store to rebuild its round keys from two key words.
   typedef struct packed {
      logic     load;
      word_type key_a;
      word_type key_b;
   } key_load_type;

   // f(x) = (x <<< 1 & x <<< 8) ^ x <<< 2
   function automatic word_type round_f(input word_type x);
      word_type r1;
      word_type r8;
      word_type r2;
      r1 = {x[62:0], x[63]};
      r8 = {x[55:0], x[63:56]};
      r2 = {x[61:0], x[63:62]};
      return (r1 & r8) ^ r2;
   endfunction

   // One step of the two-word key schedule.
   function automatic word_type key_next(input word_type a, input word_type b,
                                         input logic zbit);
      word_type t;
      t = {b[2:0], b[63:3]};
      t = t ^ {t[0], t[63:1]};
      return a ^ t ^ CONST_C ^ {{(WORD_W-1){1'b0}}, zbit};
   endfunction

endpackage

`default_nettype wire

[src/simon_if.sv]
// Valid/ready channel interfaces for the cipher: request, response, and
// configuration write. Depends on simon_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface simon_req_if import simon_pkg::*; ();
   logic     valid;
   logic     ready;
   logic     cmd;
   word_type block_left;
   word_type block_right;

   modport source (output valid, output cmd, output block_left, output block_right,
                   input ready);
   modport sink (input valid, input cmd, input block_left, input block_right,
                 output ready);
endinterface

interface simon_rsp_if import simon_pkg::*; ();
   logic     valid;
   logic     ready;
   word_type result_left;
   word_type result_right;

   modport source (output valid, output result_left, output result_right, input ready);
   modport sink (input valid, input result_left, input result_right, output ready);
endinterface

interface simon_csr_if import simon_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   word_type             data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[src/simon_key_store.sv]
// Round key store with its expansion sequencer: one key written per cycle
// after a load, one registered read port for the round datapath.
// Depends on simon_pkg.
`timescale 1ns / 1ps
`default_nettype none

module simon_key_store import simon_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire key_load_type       load,
   output logic                    busy,
   input  wire logic [KADDR_W-1:0] rd_addr,
   output word_type                rd_data
);

   logic              busy_ff, busy_in;
   logic [KADDR_W-1:0] cnt_ff, cnt_in;
   logic [ZIDX_W-1:0]  zidx_ff, zidx_in;
   word_type           a_ff, a_in;
   word_type           b_ff, b_in;
   word_type           rd_data_ff;
   word_type           mem [KEY_DEPTH];

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      zidx_in = zidx_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      if (load.load) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         zidx_in = '0;
         a_in    = load.key_a;
         b_in    = load.key_b;
      end else if (busy_ff) begin
         // The word in a_ff is stored this cycle; the pair then shifts on.
         a_in    = b_ff;
         b_in    = key_next(a_ff, b_ff, Z2_SEQ[zidx_ff]);
         zidx_in = (zidx_ff == ZIDX_W'(Z_LEN - 1)) ? '0 : zidx_ff + 1'b1;
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == KADDR_W'(KEY_DEPTH - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      cnt_ff  <= cnt_in;
      zidx_ff <= zidx_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
   end

   always_ff @(posedge clock) begin
      if (busy_ff) begin
         mem[cnt_ff] <= a_ff;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign busy    = busy_ff;
   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[src/simon_128_128_block_cipher.sv]
// Simon 128/128 block cipher top level: configuration decode, sequencer
// and the shared round unit. Depends on simon_pkg, simon_if, simon_key_store.
//
// Usage:
//   csr_if  writes the key words: index CSR_IDX_KEY_LOW for key bytes 0 to 7,
//           CSR_IDX_KEY_HIGH for bytes 8 to 15; other indexes are ignored.
//           Each key write rebuilds the 68 round keys, one per cycle, and
//           the block takes neither a request nor another write until
//           the rebuild is done.
//   req_if  carries one request: cmd (encrypt or decrypt) and the block.
//   rsp_if  returns one result block for each request.
// A request passes from acceptance to a valid response through FETCH, which
// reads the first round key, ROUND, which runs the rounds in turn in the single
// round unit (one key store read per round), and FINISH, which formats the result.
// A new request is taken only once the previous result has left the sequencer.
// Reset clears the sequencer, the key words (to zero) and the response
// valid; the round keys are undefined until a key word is written.
// If the receiver stalls, the finished result waits in the sequencer until
// the response register is free; the response register itself holds while
// the next request is accepted and processed.
`timescale 1ns / 1ps
`default_nettype none

module simon_128_128_block_cipher import simon_pkg::*; #(
   parameter int ROUNDS = SIMON_ROUNDS
) (
   input  wire logic  clock,
   input  wire logic  reset,
   simon_csr_if.sink  csr_if,
   simon_req_if.sink  req_if,
   simon_rsp_if.source rsp_if
);

   localparam int RND_W = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_KEYGEN = 3'd1;
   localparam logic [2:0] ST_FETCH  = 3'd2;
   localparam logic [2:0] ST_ROUND  = 3'd3;
   localparam logic [2:0] ST_FINISH = 3'd4;

   logic [2:0]         state_ff, state_in;
   word_type           key_low_ff, key_low_in;
   word_type           key_high_ff, key_high_in;
   word_type           x_ff, x_in;
   word_type           y_ff, y_in;
   logic               dec_ff, dec_in;
   logic [KADDR_W-1:0] kaddr_ff, kaddr_in;
   logic [RND_W-1:0]   rnd_ff, rnd_in;
   logic               rsp_valid_ff, rsp_valid_in;
   word_type           rsp_left_ff, rsp_left_in;
   word_type           rsp_right_ff, rsp_right_in;

   key_load_type load;
   logic         ks_busy;
   word_type     round_key;
   logic         csr_fire;
   logic         req_fire;
   logic         last_round;

   simon_key_store u_key_store (
      .clock   (clock),
      .reset   (reset),
      .load    (load),
      .busy    (ks_busy),
      .rd_addr (kaddr_ff),
      .rd_data (round_key)
   );

   assign csr_if.ready = (state_ff == ST_IDLE);
   // A pending key write takes precedence over a request in the same cycle.
   assign req_if.ready = (state_ff == ST_IDLE) && !csr_if.valid;
   assign csr_fire     = csr_if.valid && csr_if.ready;
   assign req_fire     = req_if.valid && req_if.ready;
   assign last_round   = (rnd_ff == RND_W'(ROUNDS - 1));

   always_comb begin
      state_in     = state_ff;
      key_low_in   = key_low_ff;
      key_high_in  = key_high_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      dec_in       = dec_ff;
      kaddr_in     = kaddr_ff;
      rnd_in       = rnd_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_left_in  = rsp_left_ff;
      rsp_right_in = rsp_right_ff;
      load         = '0;

      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff) inside
         ST_IDLE: begin
            if (csr_fire) begin
               unique case (csr_if.index)
                  CSR_IDX_KEY_LOW: begin
                     key_low_in = csr_if.data;
                     load       = '{load: 1'b1, key_a: csr_if.data, key_b: key_high_ff};
                     state_in   = ST_KEYGEN;
                  end
                  CSR_IDX_KEY_HIGH: begin
                     key_high_in = csr_if.data;
                     load        = '{load: 1'b1, key_a: key_low_ff, key_b: csr_if.data};
                     state_in    = ST_KEYGEN;
                  end
                  default: ;
               endcase
            end else if (req_fire) begin
               dec_in = req_if.cmd;
               rnd_in = '0;
               // Decryption runs the same rounds on swapped halves with the
               // keys taken in reverse order.
               if (req_if.cmd == CMD_DECRYPT) begin
                  x_in     = req_if.block_right;
                  y_in     = req_if.block_left;
                  kaddr_in = KADDR_W'(ROUNDS - 1);
               end else begin
                  x_in     = req_if.block_left;
                  y_in     = req_if.block_right;
                  kaddr_in = '0;
               end
               state_in = ST_FETCH;
            end
         end
         ST_KEYGEN: begin
            if (!ks_busy) begin
               state_in = ST_IDLE;
            end
         end
         ST_FETCH, ST_ROUND: begin
            if (state_ff == ST_ROUND) begin
               x_in   = y_ff ^ round_f(x_ff) ^ round_key;
               y_in   = x_ff;
               rnd_in = rnd_ff + 1'b1;
               if (last_round) begin
                  state_in = ST_FINISH;
               end
            end else begin
               state_in = ST_ROUND;
            end
            // Fetch the key for the following round, staying in range: once
            // the key for the last round has been read, the address holds.
            if (!(state_ff == ST_ROUND && rnd_ff >= RND_W'(ROUNDS - 2))
                && !(ROUNDS == 1)) begin
               kaddr_in = (dec_ff == CMD_DECRYPT) ? kaddr_ff - 1'b1 : kaddr_ff + 1'b1;
            end
            if (state_ff == ST_FETCH && last_round) begin
               kaddr_in = kaddr_ff;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in = 1'b1;
               if (dec_ff == CMD_DECRYPT) begin
                  rsp_left_in  = y_ff;
                  rsp_right_in = x_ff;
               end else begin
                  rsp_left_in  = x_ff;
                  rsp_right_in = y_ff;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         key_low_ff   <= '0;
         key_high_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         key_low_ff   <= key_low_in;
         key_high_ff  <= key_high_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      x_ff         <= x_in;
      y_ff         <= y_in;
      dec_ff       <= dec_in;
      kaddr_ff     <= kaddr_in;
      rnd_ff       <= rnd_in;
      rsp_left_ff  <= rsp_left_in;
      rsp_right_ff <= rsp_right_in;
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.result_left  = rsp_left_ff;
   assign rsp_if.result_right = rsp_right_ff;

endmodule

`default_nettype wire

[src/simon_checker.sv]
// Port-level checks for the Simon cipher top level, attached by bind.
// Depends on simon_pkg and simon_128_128_block_cipher.
`timescale 1ns / 1ps
`default_nettype none

module simon_checker import simon_pkg::*; (
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 req_valid,
   input wire logic                 req_ready,
   input wire logic                 rsp_valid,
   input wire logic                 rsp_ready,
   input wire word_type             rsp_left,
   input wire word_type             rsp_right,
   input wire logic                 csr_valid,
   input wire logic                 csr_ready,
   input wire logic [CSR_IDX_W-1:0] csr_index
);

   // A stalled response must stay offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // A stalled response must keep its data.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_left) && $stable(rsp_right))
      else $error("response data changed while stalled");

   // The block works on one request at a time.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready && !csr_ready)
      else $error("channel ready right after a request was accepted");

   // A write to one of the key words starts expansion, which blocks requests.
   // Writes to unmapped indexes are ignored and leave the block idle.
   assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_ready
         && (csr_index == CSR_IDX_KEY_LOW || csr_index == CSR_IDX_KEY_HIGH)
      |=> !req_ready)
      else $error("request ready right after a key write");

   // No response can appear in the cycle after a request is taken.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !$rose(rsp_valid))
      else $error("response appeared too early");

endmodule

bind simon_128_128_block_cipher simon_checker u_simon_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_if.valid),
   .req_ready (req_if.ready),
   .rsp_valid (rsp_if.valid),
   .rsp_ready (rsp_if.ready),
   .rsp_left  (rsp_if.result_left),
   .rsp_right (rsp_if.result_right),
   .csr_valid (csr_if.valid),
   .csr_ready (csr_if.ready),
   .csr_index (csr_if.index)
);

`default_nettype wire
